// ===== design/tri3_pkg.sv =====
// tri3_pkg: shared types and constants for the linear triangle gradient pipeline
// holds the fixed-point formats, status codes and the input/output word structs
// no dependencies
`timescale 1ns / 1ps

package tri3_pkg;

  // fixed-point formats
  localparam int CoordBits  = 32;
  localparam int FracBits   = 16;
  localparam int RefBits    = FracBits + 1;
  localparam int ShapeBits  = FracBits + 2;
  localparam int WdetBits   = 64;

  // internal widths
  localparam int JacBits    = CoordBits + 1;
  localparam int DetBits    = 2 * JacBits + 1;
  localparam int ProdBits   = JacBits + RefBits + 1;
  localparam int PtBits     = CoordBits + FracBits + 5;
  localparam int WdBits     = DetBits + RefBits + 1;
  localparam int RemBits    = JacBits + 2 * FracBits;
  localparam int CmpBits    = (RemBits > DetBits - 1 + CoordBits) ?
                              RemBits : DetBits - 1 + CoordBits;
  localparam int NumGrads   = 6;

  typedef enum logic [1:0] {
    StOk   = 2'd0,
    StNeg  = 2'd1,
    StZero = 2'd2
  } status_e;

  typedef struct packed {
    logic [RefBits-1:0]          xi;
    logic [RefBits-1:0]          eta;
    logic [RefBits-1:0]          weight;
    logic signed [CoordBits-1:0] node0_x;
    logic signed [CoordBits-1:0] node0_y;
    logic signed [CoordBits-1:0] node1_x;
    logic signed [CoordBits-1:0] node1_y;
    logic signed [CoordBits-1:0] node2_x;
    logic signed [CoordBits-1:0] node2_y;
  } tri3_in_t;

  typedef struct packed {
    logic signed [ShapeBits-1:0] shape_first;
    logic signed [CoordBits-1:0] point_x;
    logic signed [CoordBits-1:0] point_y;
    logic signed [CoordBits-1:0] grad0_x;
    logic signed [CoordBits-1:0] grad0_y;
    logic signed [CoordBits-1:0] grad1_x;
    logic signed [CoordBits-1:0] grad1_y;
    logic signed [CoordBits-1:0] grad2_x;
    logic signed [CoordBits-1:0] grad2_y;
    logic signed [WdetBits-1:0]  weighted_det;
    status_e                     status;
  } tri3_out_t;

endpackage

// ===== design/tri3_element_jacobian_gradients.sv =====
// each word passes stages a to d, the divider entry, the divider and the output register
// throughput: one word per cycle unless the output stalls; the six gradient quotients
// run in a restoring divider pipelined one quotient bit per stage, which sets the depth
// a stall on the output freezes the whole pipeline, no word is lost or repeated
// reset clears all stage valid bits, payload registers are not reset
// tri3_element_jacobian_gradients: top level, depends on tri3_pkg
`timescale 1ns / 1ps

module tri3_element_jacobian_gradients (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  tri3_pkg::tri3_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output tri3_pkg::tri3_out_t out_data_o
);
  import tri3_pkg::*;

  typedef struct packed {
    logic [NumGrads-1:0][RemBits-1:0]   rem;
    logic [NumGrads-1:0][CoordBits-1:0] quo;
    logic [NumGrads-1:0]                neg;
    logic [NumGrads-1:0]                ovf;
    logic [DetBits-2:0]                 dpos;
    logic signed [ShapeBits-1:0]        shape;
    logic signed [CoordBits-1:0]        px;
    logic signed [CoordBits-1:0]        py;
    logic signed [WdetBits-1:0]         wdet;
    status_e                            status;
  } div_t;

  // saturate the floored point to the coordinate range
  function automatic logic [CoordBits-1:0] sat_pt(input logic [PtBits-FracBits-1:0] v);
    logic all_one, all_zero;
    all_one  = &v[PtBits-FracBits-1:CoordBits-1];
    all_zero = ~|v[PtBits-FracBits-1:CoordBits-1];
    if (all_one || all_zero) return v[CoordBits-1:0];
    else if (v[PtBits-FracBits-1]) return {1'b1, {(CoordBits-1){1'b0}}};
    else return {1'b0, {(CoordBits-1){1'b1}}};
  endfunction

  // saturate the scaled determinant to 64 bits
  function automatic logic [WdetBits-1:0] sat_wd(input logic [WdBits-FracBits-1:0] v);
    logic all_one, all_zero;
    all_one  = &v[WdBits-FracBits-1:WdetBits-1];
    all_zero = ~|v[WdBits-FracBits-1:WdetBits-1];
    if (all_one || all_zero) return v[WdetBits-1:0];
    else if (v[WdBits-FracBits-1]) return {1'b1, {(WdetBits-1){1'b0}}};
    else return {1'b0, {(WdetBits-1){1'b1}}};
  endfunction

  // apply sign and saturate a quotient magnitude
  function automatic logic [CoordBits-1:0] sat_grad(input logic [CoordBits:0] q,
                                                     input logic neg);
    logic big;
    big = q[CoordBits] | q[CoordBits-1];
    if (!neg) return big ? {1'b0, {(CoordBits-1){1'b1}}} : q[CoordBits-1:0];
    else return big ? {1'b1, {(CoordBits-1){1'b0}}} : CoordBits'(-q[CoordBits-1:0]);
  endfunction

  logic adv;
  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;

  // stage a: jacobian differences and first shape value
  logic a_vld_q;
  logic signed [JacBits-1:0]   a_j00_q, a_j01_q, a_j10_q, a_j11_q;
  logic signed [CoordBits-1:0] a_x0_q, a_y0_q;
  logic [RefBits-1:0]          a_xi_q, a_eta_q, a_wt_q;
  logic signed [ShapeBits-1:0] a_shape_q;
  logic signed [ShapeBits:0]   a_shape_d;
  logic signed [ShapeBits-1:0] a_shape_sat;

  assign a_shape_d = (ShapeBits+1)'(1 << FracBits) - (ShapeBits+1)'(in_data_i.xi)
                   - (ShapeBits+1)'(in_data_i.eta);

  // clamp the shape value to its signed range
  always_comb begin
    if (a_shape_d[ShapeBits] != a_shape_d[ShapeBits-1]) begin
      a_shape_sat = a_shape_d[ShapeBits] ? {1'b1, {(ShapeBits-1){1'b0}}}
                                         : {1'b0, {(ShapeBits-1){1'b1}}};
    end else begin
      a_shape_sat = a_shape_d[ShapeBits-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_j00_q   <= JacBits'(in_data_i.node1_x) - JacBits'(in_data_i.node0_x);
      a_j01_q   <= JacBits'(in_data_i.node1_y) - JacBits'(in_data_i.node0_y);
      a_j10_q   <= JacBits'(in_data_i.node2_x) - JacBits'(in_data_i.node0_x);
      a_j11_q   <= JacBits'(in_data_i.node2_y) - JacBits'(in_data_i.node0_y);
      a_x0_q    <= in_data_i.node0_x;
      a_y0_q    <= in_data_i.node0_y;
      a_xi_q    <= in_data_i.xi;
      a_eta_q   <= in_data_i.eta;
      a_wt_q    <= in_data_i.weight;
      a_shape_q <= a_shape_sat;
    end
  end

  // stage b: products and gradient numerators
  logic b_vld_q;
  logic signed [2*JacBits-1:0] b_p0_q, b_p1_q;
  logic signed [ProdBits-1:0]  b_pxa_q, b_pxb_q, b_pya_q, b_pyb_q;
  logic signed [CoordBits-1:0] b_x0_q, b_y0_q;
  logic [RefBits-1:0]          b_wt_q;
  logic signed [ShapeBits-1:0] b_shape_q;
  logic [NumGrads-1:0][JacBits-1:0] b_nmag_q;
  logic [NumGrads-1:0]         b_nneg_q;
  logic signed [JacBits:0]     nv [NumGrads];
  logic [NumGrads-1:0][JacBits-1:0] nmag_d;
  logic [NumGrads-1:0]         nneg_d;
  logic signed [RefBits:0]     xi_s, eta_s;

  assign xi_s  = $signed({1'b0, a_xi_q});
  assign eta_s = $signed({1'b0, a_eta_q});

  always_comb begin
    nv[0] = (JacBits+1)'(a_j01_q) - (JacBits+1)'(a_j11_q);
    nv[1] = (JacBits+1)'(a_j10_q) - (JacBits+1)'(a_j00_q);
    nv[2] = (JacBits+1)'(a_j11_q);
    nv[3] = -(JacBits+1)'(a_j10_q);
    nv[4] = -(JacBits+1)'(a_j01_q);
    nv[5] = (JacBits+1)'(a_j00_q);
    for (int k = 0; k < NumGrads; k++) begin
      nneg_d[k] = nv[k][JacBits];
      nmag_d[k] = nv[k][JacBits] ? JacBits'(-nv[k]) : nv[k][JacBits-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      b_p0_q    <= a_j00_q * a_j11_q;
      b_p1_q    <= a_j01_q * a_j10_q;
      b_pxa_q   <= ProdBits'(a_j00_q) * ProdBits'(xi_s);
      b_pxb_q   <= ProdBits'(a_j10_q) * ProdBits'(eta_s);
      b_pya_q   <= ProdBits'(a_j01_q) * ProdBits'(xi_s);
      b_pyb_q   <= ProdBits'(a_j11_q) * ProdBits'(eta_s);
      b_x0_q    <= a_x0_q;
      b_y0_q    <= a_y0_q;
      b_wt_q    <= a_wt_q;
      b_shape_q <= a_shape_q;
      b_nmag_q  <= nmag_d;
      b_nneg_q  <= nneg_d;
    end
  end

  // stage c: determinant and mapped point sums
  logic c_vld_q;
  logic signed [DetBits-1:0]   c_det_q;
  logic signed [PtBits-1:0]    c_px_q, c_py_q;
  logic [RefBits-1:0]          c_wt_q;
  logic signed [ShapeBits-1:0] c_shape_q;
  logic [NumGrads-1:0][JacBits-1:0] c_nmag_q;
  logic [NumGrads-1:0]         c_nneg_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c_det_q   <= DetBits'(b_p0_q) - DetBits'(b_p1_q);
      c_px_q    <= (PtBits'(b_x0_q) <<< FracBits) + PtBits'(b_pxa_q) + PtBits'(b_pxb_q);
      c_py_q    <= (PtBits'(b_y0_q) <<< FracBits) + PtBits'(b_pya_q) + PtBits'(b_pyb_q);
      c_wt_q    <= b_wt_q;
      c_shape_q <= b_shape_q;
      c_nmag_q  <= b_nmag_q;
      c_nneg_q  <= b_nneg_q;
    end
  end

  // stage d: weighted determinant product, point saturation, status
  logic d_vld_q;
  logic signed [WdBits-1:0]    d_wd_q;
  logic signed [CoordBits-1:0] d_px_q, d_py_q;
  logic [DetBits-2:0]          d_dpos_q;
  status_e                     d_status_q, status_d;
  logic signed [ShapeBits-1:0] d_shape_q;
  logic [NumGrads-1:0][JacBits-1:0] d_nmag_q;
  logic [NumGrads-1:0]         d_nneg_q;
  logic signed [RefBits:0]     wt_s;

  assign wt_s = $signed({1'b0, c_wt_q});

  always_comb begin
    if (c_det_q == '0) status_d = StZero;
    else if (c_det_q[DetBits-1]) status_d = StNeg;
    else status_d = StOk;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      d_wd_q     <= WdBits'(c_det_q) * WdBits'(wt_s);
      d_px_q     <= sat_pt(c_px_q[PtBits-1:FracBits]);
      d_py_q     <= sat_pt(c_py_q[PtBits-1:FracBits]);
      d_dpos_q   <= c_det_q[DetBits-2:0];
      d_status_q <= status_d;
      d_shape_q  <= c_shape_q;
      d_nmag_q   <= c_nmag_q;
      d_nneg_q   <= c_nneg_q;
    end
  end

  // divider entry: overflow check and initial remainders
  div_t dv_q [CoordBits+1];
  logic [CoordBits:0] dv_vld_q;
  div_t dv_first_d;

  always_comb begin
    dv_first_d        = '0;
    dv_first_d.dpos   = d_dpos_q;
    dv_first_d.shape  = d_shape_q;
    dv_first_d.px     = d_px_q;
    dv_first_d.py     = d_py_q;
    dv_first_d.wdet   = sat_wd(d_wd_q[WdBits-1:FracBits]);
    dv_first_d.status = d_status_q;
    dv_first_d.neg    = d_nneg_q;
    for (int k = 0; k < NumGrads; k++) begin
      dv_first_d.rem[k] = {d_nmag_q[k], {(2*FracBits){1'b0}}};
      dv_first_d.ovf[k] = CmpBits'({d_nmag_q[k], {(2*FracBits){1'b0}}})
                        >= (CmpBits'(d_dpos_q) << CoordBits);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) dv_q[0] <= dv_first_d;
  end

  // one quotient bit per stage, most significant first
  for (genvar s = 0; s < CoordBits; s++) begin : g_div
    localparam int Bit = CoordBits - 1 - s;
    div_t nxt_d;
    logic [CmpBits-1:0] dsh;

    assign dsh = CmpBits'(dv_q[s].dpos) << Bit;

    always_comb begin
      nxt_d = dv_q[s];
      for (int k = 0; k < NumGrads; k++) begin
        if (CmpBits'(dv_q[s].rem[k]) >= dsh) begin
          nxt_d.rem[k]      = RemBits'(CmpBits'(dv_q[s].rem[k]) - dsh);
          nxt_d.quo[k][Bit] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) dv_q[s+1] <= nxt_d;
    end
  end

  // output register: sign, saturation and masking of gradients
  tri3_out_t out_q, out_d;
  logic out_vld_q;
  logic [NumGrads-1:0][CoordBits-1:0] grad;

  always_comb begin
    for (int k = 0; k < NumGrads; k++) begin
      if (dv_q[CoordBits].status != StOk) grad[k] = '0;
      else if (dv_q[CoordBits].ovf[k])
        grad[k] = sat_grad({1'b1, {CoordBits{1'b0}}}, dv_q[CoordBits].neg[k]);
      else
        grad[k] = sat_grad({1'b0, dv_q[CoordBits].quo[k]}, dv_q[CoordBits].neg[k]);
    end
    out_d.shape_first  = dv_q[CoordBits].shape;
    out_d.point_x      = dv_q[CoordBits].px;
    out_d.point_y      = dv_q[CoordBits].py;
    out_d.grad0_x      = grad[0];
    out_d.grad0_y      = grad[1];
    out_d.grad1_x      = grad[2];
    out_d.grad1_y      = grad[3];
    out_d.grad2_x      = grad[4];
    out_d.grad2_y      = grad[5];
    out_d.weighted_det = dv_q[CoordBits].wdet;
    out_d.status       = dv_q[CoordBits].status;
  end

  always_ff @(posedge clk_i) begin
    if (adv) out_q <= out_d;
  end

  // stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q   <= 1'b0;
      b_vld_q   <= 1'b0;
      c_vld_q   <= 1'b0;
      d_vld_q   <= 1'b0;
      dv_vld_q  <= '0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      a_vld_q   <= in_valid_i;
      b_vld_q   <= a_vld_q;
      c_vld_q   <= b_vld_q;
      d_vld_q   <= c_vld_q;
      dv_vld_q  <= {dv_vld_q[CoordBits-1:0], d_vld_q};
      out_vld_q <= dv_vld_q[CoordBits];
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

// ===== design/tri3_chk.sv =====
// tri3_chk: port-level checks for the triangle gradient pipeline
// depends on tri3_pkg; bound to tri3_element_jacobian_gradients at the end of this file
`timescale 1ns / 1ps

module tri3_chk (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input tri3_pkg::tri3_in_t  in_data_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input tri3_pkg::tri3_out_t out_data_o
);
  import tri3_pkg::*;

  // a stalled result word stays valid
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result word dropped under stall");

  // input is held off only by a stalled result word
  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");

  // gradients are zero unless the determinant is positive
  a_grad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != StOk |->
      out_data_o.grad0_x == '0 && out_data_o.grad0_y == '0 &&
      out_data_o.grad1_x == '0 && out_data_o.grad1_y == '0 &&
      out_data_o.grad2_x == '0 && out_data_o.grad2_y == '0)
    else $error("nonzero gradient on degenerate element");

  // zero determinant gives zero weighted determinant
  a_wdet_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == StZero |-> out_data_o.weighted_det == '0)
    else $error("weighted determinant nonzero on zero determinant");

endmodule

bind tri3_element_jacobian_gradients tri3_chk u_tri3_chk (.*);

// ===== tb/sv/tri3_element_jacobian_gradients_tb.sv =====
// tri3_element_jacobian_gradients_tb: self-checking bench for the triangle gradient pipeline
// predicts every result word with a local fixed-point model and checks it in order
// depends on tri3_pkg and tri3_element_jacobian_gradients
`timescale 1ns / 1ps

module tri3_element_jacobian_gradients_tb;
  import tri3_pkg::*;

  localparam int RefOne    = 1 << FracBits;
  localparam int Latency   = 4 + CoordBits + 2;
  localparam int MaxCycles = 1000000;

  // reference arithmetic on wide signed values
  function automatic logic signed [127:0] clamp_signed(logic signed [127:0] v, int n);
    logic signed [127:0] top;
    logic signed [127:0] bot;
    top = (128'sd1 <<< (n - 1)) - 1;
    bot = -(128'sd1 <<< (n - 1));
    if (v > top) return top;
    if (v < bot) return bot;
    return v;
  endfunction

  function automatic logic signed [CoordBits-1:0] shape_gradient(logic signed [127:0] num,
                                                                 logic signed [127:0] det);
    logic signed [127:0] mag;
    logic signed [127:0] quo;
    mag = (num < 0) ? -num : num;
    quo = (mag <<< (2 * FracBits)) / det;
    if (num < 0) quo = -quo;
    return CoordBits'(clamp_signed(quo, CoordBits));
  endfunction

  function automatic tri3_out_t predict_element(tri3_in_t w);
    tri3_out_t r;
    logic signed [127:0] xi, eta, wt, x0, y0, x1, y1, x2, y2;
    logic signed [127:0] j00, j01, j10, j11, det, px, py;
    xi = $signed({111'd0, w.xi});
    eta = $signed({111'd0, w.eta});
    wt = $signed({111'd0, w.weight});
    x0 = w.node0_x; y0 = w.node0_y; x1 = w.node1_x;
    y1 = w.node1_y; x2 = w.node2_x; y2 = w.node2_y;
    j00 = x1 - x0; j01 = y1 - y0; j10 = x2 - x0; j11 = y2 - y0;
    det = j00 * j11 - j01 * j10;
    px = (x0 <<< FracBits) + j00 * xi + j10 * eta;
    py = (y0 <<< FracBits) + j01 * xi + j11 * eta;
    r = '0;
    r.shape_first = ShapeBits'(clamp_signed(RefOne - xi - eta, ShapeBits));
    r.point_x = CoordBits'(clamp_signed(px >>> FracBits, CoordBits));
    r.point_y = CoordBits'(clamp_signed(py >>> FracBits, CoordBits));
    r.weighted_det = WdetBits'(clamp_signed((det * wt) >>> FracBits, WdetBits));
    if (det == 0) begin
      r.status = StZero;
    end else if (det < 0) begin
      r.status = StNeg;
    end else begin
      r.grad0_x = shape_gradient(j01 - j11, det);
      r.grad0_y = shape_gradient(j10 - j00, det);
      r.grad1_x = shape_gradient(j11, det);
      r.grad1_y = shape_gradient(-j10, det);
      r.grad2_x = shape_gradient(-j01, det);
      r.grad2_y = shape_gradient(j00, det);
      r.status = StOk;
    end
    return r;
  endfunction

  // in-order store of predicted words
  class element_scoreboard;
    tri3_out_t expected_q[$];
    int mismatches;

    function void note_input(tri3_in_t w);
      expected_q.push_back(predict_element(w));
    endfunction

    function void check_result(tri3_out_t got);
      tri3_out_t exp_w;
      if (expected_q.size() == 0) begin
        report(got, '0, "unexpected word");
        return;
      end
      exp_w = expected_q.pop_front();
      if (got !== exp_w) report(got, exp_w, "field mismatch");
    endfunction

    function void report(tri3_out_t got, tri3_out_t exp_w, string what);
      mismatches++;
      if (mismatches <= 10) begin
        $display("%s: shape %0d/%0d pt %0d,%0d / %0d,%0d", what, got.shape_first,
                 exp_w.shape_first, got.point_x, got.point_y, exp_w.point_x, exp_w.point_y);
        $display("  grad0 %0d,%0d / %0d,%0d grad1 %0d,%0d / %0d,%0d", got.grad0_x,
                 got.grad0_y, exp_w.grad0_x, exp_w.grad0_y, got.grad1_x, got.grad1_y,
                 exp_w.grad1_x, exp_w.grad1_y);
        $display("  grad2 %0d,%0d / %0d,%0d wdet %0d / %0d status %0d / %0d", got.grad2_x,
                 got.grad2_y, exp_w.grad2_x, exp_w.grad2_y, got.weighted_det,
                 exp_w.weighted_det, got.status, exp_w.status);
      end
    endfunction
  endclass

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  tri3_in_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  tri3_out_t out_data_o;

  element_scoreboard board = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_cycles = 0;
  int cycle_count = 0;

  tri3_element_jacobian_gradients dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > MaxCycles) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // receiver: random stall plus long hold-off on request
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) board.check_result(out_data_o);
    if (hold_cycles > 0) begin
      out_stall_i <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  function automatic logic [RefBits-1:0] rand_ref();
    case ($urandom_range(5))
      0: return '0;
      1: return RefBits'(RefOne);
      2: return RefBits'($urandom);
      default: return RefBits'($urandom_range(RefOne));
    endcase
  endfunction

  function automatic logic signed [CoordBits-1:0] rand_coord();
    case ($urandom_range(7))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $urandom;
      default: return $signed($urandom_range(40 << FracBits)) - (20 << FracBits);
    endcase
  endfunction

  // mostly ordinary triangles, some degenerate, some extreme
  function automatic tri3_in_t rand_word();
    tri3_in_t w;
    w.xi = rand_ref();
    w.eta = rand_ref();
    w.weight = rand_ref();
    w.node0_x = rand_coord(); w.node0_y = rand_coord();
    w.node1_x = rand_coord(); w.node1_y = rand_coord();
    w.node2_x = rand_coord(); w.node2_y = rand_coord();
    if ($urandom_range(9) == 0) begin
      w.node2_x = w.node1_x;
      w.node2_y = w.node1_y;
    end
    return w;
  endfunction

  // offer one word and hold it until accepted
  task automatic send_word(tri3_in_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    board.note_input(w);
  endtask

  task automatic go_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    go_idle();
    while (board.expected_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_tri(logic [RefBits-1:0] xi, logic [RefBits-1:0] eta,
                          logic [RefBits-1:0] wt, int x0, int y0, int x1, int y1,
                          int x2, int y2);
    tri3_in_t w;
    w = '{xi, eta, wt, x0, y0, x1, y1, x2, y2};
    send_word(w);
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: unit triangle, flipped, degenerate, extremes
    send_tri(0, 0, RefOne, 0, 0, RefOne, 0, 0, RefOne);
    send_tri(RefOne, 0, RefOne, 0, 0, RefOne, 0, 0, RefOne);
    send_tri(0, RefOne, RefOne, 0, 0, RefOne, 0, 0, RefOne);
    send_tri(RefOne / 3, RefOne / 3, RefOne / 2, 0, 0, RefOne, 0, 0, RefOne);
    send_tri(RefOne / 4, RefOne / 4, RefOne, 0, 0, 0, RefOne, RefOne, 0);
    send_tri(RefOne / 2, 0, RefOne, 5, 5, 7, 9, 11, 13);
    send_tri(RefOne, RefOne, RefOne, 0, 0, RefOne, RefOne, 2 * RefOne, 2 * RefOne);
    send_tri(17'h1ffff, 17'h1ffff, 17'h1ffff, 0, 0, RefOne, 0, 0, RefOne);
    send_tri(0, 0, 0, 0, 0, RefOne, 0, 0, RefOne);
    send_tri(RefOne, RefOne, RefOne, 32'sh80000000, 32'sh80000000, 32'sh7fffffff,
             32'sh80000000, 32'sh80000000, 32'sh7fffffff);
    send_tri(RefOne, RefOne, RefOne, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000,
             32'sh7fffffff, 32'sh7fffffff, 32'sh80000000);
    send_tri(RefOne, RefOne, RefOne, 32'sh80000000, 32'sh80000000, 32'sh7fffffff,
             32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
    send_tri(RefOne, 0, RefOne, 0, 0, 1, 0, 0, 1);
    send_tri(0, RefOne, RefOne, 0, 0, 1, 0, 1, 1);
    send_tri(RefOne / 2, RefOne / 2, RefOne, -3, 4, 32'sh7fffffff, 0, 0, 2);
    send_tri(0, 0, 17'h1ffff, 0, 0, 0, 0, 0, 0);
    send_tri(17'h15555, 17'h0aaaa, 17'h0aaaa, 32'sh55555555, 32'shaaaaaaaa,
             32'shaaaaaaaa, 32'sh55555555, 32'sh55555555, 32'sh55555555);
    send_tri(17'h0aaaa, 17'h15555, 17'h15555, 32'shaaaaaaaa, 32'sh55555555,
             32'sh55555555, 32'shaaaaaaaa, 32'shaaaaaaaa, 32'shaaaaaaaa);
    drain();

    // sender pauses until empty, then a long receiver hold-off while it keeps sending
    hold_cycles <= 200;
    repeat (150) send_word(rand_word());

    // random phases with different idle mixes
    send_idle_pct = 6; recv_idle_pct = 46;
    repeat (500) send_word(rand_word());
    send_idle_pct = 46; recv_idle_pct = 6;
    repeat (500) send_word(rand_word());
    drain();
    send_idle_pct = 0; recv_idle_pct = 0;
    repeat (500) send_word(rand_word());
    drain();
    repeat (Latency * 2) @(posedge clk_i);

    if (board.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
